// ===== rtl/core/terrain_ground_height_query_macros.svh =====
// Assertion macros for the terrain ground height query block.
// The using module must have clk and rst_n in scope.
`ifndef TERRAIN_GROUND_HEIGHT_QUERY_MACROS_SVH
`define TERRAIN_GROUND_HEIGHT_QUERY_MACROS_SVH
`ifndef SYNTHESIS
`define TGHQ_ASSERT_IMP(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");
`define TGHQ_ASSERT_NXT(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");
`else
`define TGHQ_ASSERT_IMP(lbl, ante, cons)
`define TGHQ_ASSERT_NXT(lbl, ante, cons)
`endif
`endif

// ===== rtl/core/tghq_pkg.sv =====
// ----------------------------------------------------------------------------
// tghq_pkg
// Constants, codes and helpers of the terrain ground height query block.
// ----------------------------------------------------------------------------
package tghq_pkg;

    localparam int MAX_TRIANGLES = 256;
    localparam int COORD_BITS    = 24;
    localparam int TRI_WORDS     = 9;
    localparam int MEM_DEPTH     = MAX_TRIANGLES * TRI_WORDS;
    localparam int ADDR_W        = $clog2(MEM_DEPTH);
    localparam int CNT_W         = $clog2(MAX_TRIANGLES + 1);
    localparam int TIDX_W        = $clog2(TRI_WORDS);

    localparam int CW      = COORD_BITS;
    localparam int DW      = CW + 1;          // coordinate difference
    localparam int XW      = 2 * DW;          // cross product / normal part
    localparam int SPLIT_W = DW;              // low slice of a normal part
    localparam int MUL_W   = 33;              // shared multiplier operand
    localparam int PROD_W  = 2 * MUL_W;
    localparam int ACC_W   = XW + DW + 1;
    localparam int QSH     = CW + 1;          // quotient clamp is 2^QSH
    localparam int QW      = CW + 2;
    localparam int HW      = CW + 3;
    localparam int NORM_BITS = 31;
    localparam int SQ_W    = 64;
    localparam int LEN_W   = 32;
    localparam int NW      = 16;
    localparam int NFRAC   = 14;
    localparam int ONE_Q14 = 16384;
    localparam int REG_W   = 16;
    localparam int CFG_IDX_W = 1;

    localparam logic [1:0] CMD_CLEAR = 2'd0;
    localparam logic [1:0] CMD_LOAD  = 2'd1;
    localparam logic [1:0] CMD_QUERY = 2'd2;

    localparam logic [CFG_IDX_W-1:0] REG_EDGE_TOL  = 1'd0;
    localparam logic [CFG_IDX_W-1:0] REG_DEGEN_THR = 1'd1;

    typedef logic signed [CW-1:0] coord_t;

    function automatic logic signed [DW-1:0] coord_diff(input coord_t a, input coord_t b);
        coord_diff = $signed({a[CW-1], a}) - $signed({b[CW-1], b});
    endfunction

    function automatic logic signed [MUL_W-1:0] ext_d(input logic signed [DW-1:0] v);
        ext_d = {{(MUL_W-DW){v[DW-1]}}, v};
    endfunction

    function automatic logic [XW-1:0] mag_x(input logic signed [XW-1:0] v);
        mag_x = v[XW-1] ? XW'(-v) : XW'(v);
    endfunction

    function automatic logic [ACC_W-1:0] mag_acc(input logic signed [ACC_W-1:0] v);
        mag_acc = v[ACC_W-1] ? ACC_W'(-v) : ACC_W'(v);
    endfunction

endpackage

// ===== rtl/core/terrain_ground_height_query.sv =====
// ----------------------------------------------------------------------------
// terrain_ground_height_query
// Triangle table with point-in-triangle ground height and normal lookup.
// ----------------------------------------------------------------------------
// Items: clear, load (one vertex word a cycle from S_LOAD into the
// single-port vertex memory; ignored when the table is full) and query.
// A query walks every stored triangle through one shared 33x33 multiplier
// and one shared restoring divider: memory reads, multiply-accumulate for
// the edge tests, the normal and the plane numerator, then a test and, for
// a hit on a sound plane, a divide unless the quotient is beyond the clamp.
// The winner's unit normal then follows (shift, squares, 32-step square
// root, three 15-step divides). in_ready is low while an item is being
// worked on; a finished result waits in the output register.
module terrain_ground_height_query
    import tghq_pkg::*;
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   cfg_write,
    input  logic [CFG_IDX_W-1:0]   cfg_index,
    input  logic [REG_W-1:0]       cfg_data,
    input  logic                   in_valid,
    output logic                   in_ready,
    input  logic [1:0]             cmd,
    input  logic signed [CW-1:0]   vert_a_x,
    input  logic signed [CW-1:0]   vert_a_y,
    input  logic signed [CW-1:0]   vert_a_z,
    input  logic signed [CW-1:0]   vert_b_x,
    input  logic signed [CW-1:0]   vert_b_y,
    input  logic signed [CW-1:0]   vert_b_z,
    input  logic signed [CW-1:0]   vert_c_x,
    input  logic signed [CW-1:0]   vert_c_y,
    input  logic signed [CW-1:0]   vert_c_z,
    input  logic signed [CW-1:0]   point_x,
    input  logic signed [CW-1:0]   point_z,
    output logic                   out_valid,
    input  logic                   out_ready,
    output logic                   hit_found,
    output logic signed [CW-1:0]   ground_height,
    output logic signed [NW-1:0]   normal_x,
    output logic signed [NW-1:0]   normal_y,
    output logic signed [NW-1:0]   normal_z
);

`include "terrain_ground_height_query_macros.svh"

    localparam logic [4:0] S_IDLE   = 5'd0;
    localparam logic [4:0] S_LOAD   = 5'd1;
    localparam logic [4:0] S_NEXT   = 5'd2;
    localparam logic [4:0] S_READ   = 5'd3;
    localparam logic [4:0] S_MUL    = 5'd4;
    localparam logic [4:0] S_TEST   = 5'd5;
    localparam logic [4:0] S_DCHK   = 5'd6;
    localparam logic [4:0] S_DIV    = 5'd7;
    localparam logic [4:0] S_HGT    = 5'd8;
    localparam logic [4:0] S_NSTART = 5'd9;
    localparam logic [4:0] S_NSHIFT = 5'd10;
    localparam logic [4:0] S_NSQ    = 5'd11;
    localparam logic [4:0] S_SQRT   = 5'd12;
    localparam logic [4:0] S_NDSET  = 5'd13;
    localparam logic [4:0] S_NSTORE = 5'd14;
    localparam logic [4:0] S_DONE   = 5'd15;

    localparam logic signed [CW-1:0] HMAX = CW'((1 << (CW - 1)) - 1);
    localparam logic signed [CW-1:0] HMIN = CW'(-(1 << (CW - 1)));

    logic [4:0]              state_reg;
    logic [CNT_W-1:0]        count_reg;
    logic [CNT_W-1:0]        tri_reg;
    logic [ADDR_W-1:0]       addr_reg;
    logic [5:0]              step_reg;
    logic [3:0]              op_reg;
    logic                    phase_reg;
    logic [1:0]              comp_reg;
    logic                    divmode_reg;
    logic [REG_W-1:0]        tol_reg;
    logic [REG_W-1:0]        thr_reg;

    coord_t                  t_reg [TRI_WORDS];
    coord_t                  px_reg;
    coord_t                  pz_reg;
    logic signed [PROD_W-1:0] prod_reg;
    logic signed [ACC_W-1:0] acc_reg;
    logic signed [XW-1:0]    c_reg [3];
    logic signed [XW-1:0]    n_reg [3];
    logic signed [XW-1:0]    best_n_reg [3];
    logic [XW-1:0]           m_reg [3];
    logic [ACC_W-1:0]        rem_reg;
    logic [ACC_W-1:0]        dvs_reg;
    logic [QW-1:0]           quo_reg;
    logic                    qneg_reg;
    logic                    found_reg;
    coord_t                  best_h_reg;
    logic [SQ_W-1:0]         sq_v_reg;
    logic [SQ_W-1:0]         sq_r_reg;
    logic [SQ_W-1:0]         sq_b_reg;
    logic [LEN_W-1:0]        len_reg;
    logic signed [NW-1:0]    nrm_reg [3];

    logic                    out_valid_reg;
    logic                    hit_reg;
    coord_t                  height_reg;
    logic signed [NW-1:0]    nx_reg;
    logic signed [NW-1:0]    ny_reg;
    logic signed [NW-1:0]    nz_reg;

    logic [CW-1:0]           mem [MEM_DEPTH];
    logic [CW-1:0]           rd_data_reg;
    logic                    mem_we;

    // vertex differences
    logic signed [DW-1:0] e1x, e1y, e1z, e2x, e2y, e2z;
    logic signed [DW-1:0] pax, paz, pbx, pbz, pcx, pcz, ecbx, ecbz, eacx, eacz;
    logic signed [MUL_W-1:0] op_a, op_b;
    logic op_sub, op_sh, op_start, op_store;
    logic signed [ACC_W-1:0] term, acc_sum;

    logic signed [XW-1:0] tol_x;
    logic                 hn, hp, degen;
    logic [XW-1:0]        abs_ny;
    logic                 div_ge;
    logic signed [HW-1:0] h_full;
    coord_t               h_sat;
    logic [XW-1:0]        m_or;
    logic [SQ_W:0]        sq_sum;
    logic                 sq_ge;
    logic [NW-1:0]        q_clamp;
    logic                 n_neg;
    logic [TIDX_W-1:0]    rd_idx;

    assign in_ready      = (state_reg == S_IDLE);
    assign out_valid     = out_valid_reg;
    assign hit_found     = hit_reg;
    assign ground_height = height_reg;
    assign normal_x      = nx_reg;
    assign normal_y      = ny_reg;
    assign normal_z      = nz_reg;
    assign mem_we        = (state_reg == S_LOAD);
    assign rd_idx        = TIDX_W'(step_reg - 6'd1);

    assign e1x  = coord_diff(t_reg[3], t_reg[0]);
    assign e1y  = coord_diff(t_reg[4], t_reg[1]);
    assign e1z  = coord_diff(t_reg[5], t_reg[2]);
    assign e2x  = coord_diff(t_reg[6], t_reg[0]);
    assign e2y  = coord_diff(t_reg[7], t_reg[1]);
    assign e2z  = coord_diff(t_reg[8], t_reg[2]);
    assign pax  = coord_diff(px_reg, t_reg[0]);
    assign paz  = coord_diff(pz_reg, t_reg[2]);
    assign pbx  = coord_diff(px_reg, t_reg[3]);
    assign pbz  = coord_diff(pz_reg, t_reg[5]);
    assign pcx  = coord_diff(px_reg, t_reg[6]);
    assign pcz  = coord_diff(pz_reg, t_reg[8]);
    assign ecbx = coord_diff(t_reg[6], t_reg[3]);
    assign ecbz = coord_diff(t_reg[8], t_reg[5]);
    assign eacx = coord_diff(t_reg[0], t_reg[6]);
    assign eacz = coord_diff(t_reg[2], t_reg[8]);

    // operand selection for the shared multiplier
    always_comb
    begin
        op_a   = ext_d(e1x);
        op_b   = ext_d(paz);
        op_sub = 1'b0;
        op_sh  = 1'b0;
        if (state_reg == S_NSQ)
        begin
            op_a = {{(MUL_W-NORM_BITS){1'b0}}, m_reg[comp_reg][NORM_BITS-1:0]};
            op_b = op_a;
        end
        else
        begin
            case (op_reg)
                4'd0:  begin op_a = ext_d(e1x);  op_b = ext_d(paz); end
                4'd1:  begin op_a = ext_d(e1z);  op_b = ext_d(pax); op_sub = 1'b1; end
                4'd2:  begin op_a = ext_d(ecbx); op_b = ext_d(pbz); end
                4'd3:  begin op_a = ext_d(ecbz); op_b = ext_d(pbx); op_sub = 1'b1; end
                4'd4:  begin op_a = ext_d(eacx); op_b = ext_d(pcz); end
                4'd5:  begin op_a = ext_d(eacz); op_b = ext_d(pcx); op_sub = 1'b1; end
                4'd6:  begin op_a = ext_d(e1y);  op_b = ext_d(e2z); end
                4'd7:  begin op_a = ext_d(e1z);  op_b = ext_d(e2y); op_sub = 1'b1; end
                4'd8:  begin op_a = ext_d(e1z);  op_b = ext_d(e2x); end
                4'd9:  begin op_a = ext_d(e1x);  op_b = ext_d(e2z); op_sub = 1'b1; end
                4'd10: begin op_a = ext_d(e1x);  op_b = ext_d(e2y); end
                4'd11: begin op_a = ext_d(e1y);  op_b = ext_d(e2x); op_sub = 1'b1; end
                // numerator, normal parts split into a signed high and unsigned low slice
                4'd12:
                begin
                    op_a  = ext_d(n_reg[0][XW-1:SPLIT_W]);
                    op_b  = ext_d(pax);
                    op_sh = 1'b1;
                end
                4'd13:
                begin
                    op_a = {{(MUL_W-SPLIT_W){1'b0}}, n_reg[0][SPLIT_W-1:0]};
                    op_b = ext_d(pax);
                end
                4'd14:
                begin
                    op_a  = ext_d(n_reg[2][XW-1:SPLIT_W]);
                    op_b  = ext_d(paz);
                    op_sh = 1'b1;
                end
                default:
                begin
                    op_a = {{(MUL_W-SPLIT_W){1'b0}}, n_reg[2][SPLIT_W-1:0]};
                    op_b = ext_d(paz);
                end
            endcase
        end
    end

    always_comb
    begin
        op_start = (!op_reg[0] && op_reg < 4'd12) || (op_reg == 4'd12);
        op_store = (op_reg[0] && op_reg < 4'd12) || (op_reg == 4'd15);
        term     = {{(ACC_W-PROD_W){prod_reg[PROD_W-1]}}, prod_reg};
        if (op_sh)
        begin
            term = term <<< SPLIT_W;
        end
        if (state_reg == S_NSQ)
        begin
            acc_sum = acc_reg + term;
        end
        else
        begin
            acc_sum = (op_start ? ACC_W'(0) : acc_reg) + (op_sub ? -term : term);
        end
    end

    always_comb
    begin
        tol_x  = $signed({{(XW-REG_W){1'b0}}, tol_reg});
        hn     = (c_reg[0] < -tol_x) || (c_reg[1] < -tol_x) || (c_reg[2] < -tol_x);
        hp     = (c_reg[0] > tol_x) || (c_reg[1] > tol_x) || (c_reg[2] > tol_x);
        abs_ny = mag_x(n_reg[1]);
        degen  = (n_reg[1] == '0) || (abs_ny < XW'(thr_reg));
        div_ge = (rem_reg >= dvs_reg);
        h_full = qneg_reg ? ($signed({{(HW-CW){t_reg[1][CW-1]}}, t_reg[1]}) +
                             $signed({{(HW-QW){1'b0}}, quo_reg}))
                          : ($signed({{(HW-CW){t_reg[1][CW-1]}}, t_reg[1]}) -
                             $signed({{(HW-QW){1'b0}}, quo_reg}));
        if (h_full > $signed({{(HW-CW){HMAX[CW-1]}}, HMAX}))
        begin
            h_sat = HMAX;
        end
        else if (h_full < $signed({{(HW-CW){HMIN[CW-1]}}, HMIN}))
        begin
            h_sat = HMIN;
        end
        else
        begin
            h_sat = h_full[CW-1:0];
        end
        m_or    = m_reg[0] | m_reg[1] | m_reg[2];
        sq_sum  = {1'b0, sq_r_reg} + {1'b0, sq_b_reg};
        sq_ge   = ({1'b0, sq_v_reg} >= sq_sum);
        q_clamp = (quo_reg > QW'(ONE_Q14)) ? NW'(ONE_Q14) : NW'(quo_reg);
        n_neg   = best_n_reg[comp_reg][XW-1] ^ best_n_reg[1][XW-1];
    end

    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            mem[addr_reg] <= t_reg[step_reg[TIDX_W-1:0]];
        end
        rd_data_reg <= mem[addr_reg];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            tol_reg <= REG_W'(7);
            thr_reg <= REG_W'(1);
        end
        else if (cfg_write)
        begin
            case (cfg_index)
                REG_EDGE_TOL:  tol_reg <= cfg_data;
                REG_DEGEN_THR: thr_reg <= cfg_data;
                default:       tol_reg <= tol_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            count_reg     <= '0;
            tri_reg       <= '0;
            addr_reg      <= '0;
            step_reg      <= '0;
            op_reg        <= '0;
            phase_reg     <= 1'b0;
            comp_reg      <= '0;
            divmode_reg   <= 1'b0;
            px_reg        <= '0;
            pz_reg        <= '0;
            prod_reg      <= '0;
            acc_reg       <= '0;
            rem_reg       <= '0;
            dvs_reg       <= '0;
            quo_reg       <= '0;
            qneg_reg      <= 1'b0;
            found_reg     <= 1'b0;
            best_h_reg    <= '0;
            sq_v_reg      <= '0;
            sq_r_reg      <= '0;
            sq_b_reg      <= '0;
            len_reg       <= '0;
            out_valid_reg <= 1'b0;
            hit_reg       <= 1'b0;
            height_reg    <= '0;
            nx_reg        <= '0;
            ny_reg        <= '0;
            nz_reg        <= '0;
            for (int k = 0; k < TRI_WORDS; k++)
            begin
                t_reg[k] <= '0;
            end
            for (int k = 0; k < 3; k++)
            begin
                c_reg[k]      <= '0;
                n_reg[k]      <= '0;
                best_n_reg[k] <= '0;
                m_reg[k]      <= '0;
                nrm_reg[k]    <= '0;
            end
        end
        else
        begin
            // in S_DONE the output register is reloaded below instead
            if (out_valid_reg && out_ready && state_reg != S_DONE)
            begin
                out_valid_reg <= 1'b0;
            end

            case (state_reg)
                S_IDLE:
                begin
                    if (in_valid)
                    begin
                        case (cmd)
                            CMD_CLEAR:
                            begin
                                count_reg <= '0;
                            end
                            CMD_LOAD:
                            begin
                                if (count_reg < CNT_W'(MAX_TRIANGLES))
                                begin
                                    t_reg[0] <= vert_a_x;
                                    t_reg[1] <= vert_a_y;
                                    t_reg[2] <= vert_a_z;
                                    t_reg[3] <= vert_b_x;
                                    t_reg[4] <= vert_b_y;
                                    t_reg[5] <= vert_b_z;
                                    t_reg[6] <= vert_c_x;
                                    t_reg[7] <= vert_c_y;
                                    t_reg[8] <= vert_c_z;
                                    addr_reg <= ADDR_W'(count_reg) * ADDR_W'(TRI_WORDS);
                                    step_reg <= '0;
                                    state_reg <= S_LOAD;
                                end
                            end
                            CMD_QUERY:
                            begin
                                px_reg     <= point_x;
                                pz_reg     <= point_z;
                                tri_reg    <= '0;
                                addr_reg   <= '0;
                                found_reg  <= 1'b0;
                                best_h_reg <= '0;
                                state_reg  <= S_NEXT;
                            end
                            default:
                            begin
                                state_reg <= S_IDLE;
                            end
                        endcase
                    end
                end

                S_LOAD:
                begin
                    addr_reg <= addr_reg + ADDR_W'(1);
                    step_reg <= step_reg + 6'd1;
                    if (step_reg == 6'(TRI_WORDS - 1))
                    begin
                        count_reg <= count_reg + CNT_W'(1);
                        state_reg <= S_IDLE;
                    end
                end

                S_NEXT:
                begin
                    step_reg <= '0;
                    if (tri_reg == count_reg)
                    begin
                        state_reg <= S_NSTART;
                    end
                    else
                    begin
                        state_reg <= S_READ;
                    end
                end

                // read data is registered and belongs to the address of the cycle before
                S_READ:
                begin
                    if (step_reg != '0)
                    begin
                        t_reg[rd_idx] <= rd_data_reg;
                    end
                    if (step_reg == 6'(TRI_WORDS))
                    begin
                        tri_reg   <= tri_reg + CNT_W'(1);
                        op_reg    <= '0;
                        phase_reg <= 1'b0;
                        state_reg <= S_MUL;
                    end
                    else
                    begin
                        addr_reg <= addr_reg + ADDR_W'(1);
                        step_reg <= step_reg + 6'd1;
                    end
                end

                S_MUL:
                begin
                    if (!phase_reg)
                    begin
                        prod_reg  <= op_a * op_b;
                        phase_reg <= 1'b1;
                    end
                    else
                    begin
                        acc_reg   <= acc_sum;
                        phase_reg <= 1'b0;
                        if (op_store)
                        begin
                            case (op_reg)
                                4'd1:    c_reg[0] <= acc_sum[XW-1:0];
                                4'd3:    c_reg[1] <= acc_sum[XW-1:0];
                                4'd5:    c_reg[2] <= acc_sum[XW-1:0];
                                4'd7:    n_reg[0] <= acc_sum[XW-1:0];
                                4'd9:    n_reg[1] <= acc_sum[XW-1:0];
                                4'd11:   n_reg[2] <= acc_sum[XW-1:0];
                                default: ;
                            endcase
                        end
                        op_reg <= op_reg + 4'd1;
                        if (op_reg == 4'd15)
                        begin
                            state_reg <= S_TEST;
                        end
                    end
                end

                S_TEST:
                begin
                    rem_reg  <= mag_acc(acc_reg);
                    dvs_reg  <= ACC_W'(abs_ny);
                    qneg_reg <= acc_reg[ACC_W-1] != n_reg[1][XW-1];
                    if (hn && hp)
                    begin
                        state_reg <= S_NEXT;
                    end
                    else if (degen)
                    begin
                        // zero quotient leaves vertex A's height
                        quo_reg   <= '0;
                        state_reg <= S_HGT;
                    end
                    else
                    begin
                        state_reg <= S_DCHK;
                    end
                end

                // quotient beyond the clamp is caught before the divide
                S_DCHK:
                begin
                    if (rem_reg >= ((dvs_reg << QSH) + dvs_reg))
                    begin
                        quo_reg   <= QW'(1) << QSH;
                        state_reg <= S_HGT;
                    end
                    else
                    begin
                        dvs_reg     <= dvs_reg << QSH;
                        quo_reg     <= '0;
                        step_reg    <= 6'(QSH);
                        divmode_reg <= 1'b0;
                        state_reg   <= S_DIV;
                    end
                end

                S_DIV:
                begin
                    if (div_ge)
                    begin
                        rem_reg <= rem_reg - dvs_reg;
                    end
                    quo_reg <= {quo_reg[QW-2:0], div_ge};
                    dvs_reg <= dvs_reg >> 1;
                    if (step_reg == '0)
                    begin
                        state_reg <= divmode_reg ? S_NSTORE : S_HGT;
                    end
                    else
                    begin
                        step_reg <= step_reg - 6'd1;
                    end
                end

                S_HGT:
                begin
                    if (!found_reg || (h_sat > best_h_reg))
                    begin
                        found_reg     <= 1'b1;
                        best_h_reg    <= h_sat;
                        best_n_reg[0] <= n_reg[0];
                        best_n_reg[1] <= n_reg[1];
                        best_n_reg[2] <= n_reg[2];
                    end
                    state_reg <= S_NEXT;
                end

                S_NSTART:
                begin
                    comp_reg  <= '0;
                    phase_reg <= 1'b0;
                    acc_reg   <= '0;
                    m_reg[0]  <= mag_x(best_n_reg[0]);
                    m_reg[1]  <= mag_x(best_n_reg[1]);
                    m_reg[2]  <= mag_x(best_n_reg[2]);
                    if (!found_reg)
                    begin
                        nrm_reg[0] <= '0;
                        nrm_reg[1] <= '0;
                        nrm_reg[2] <= '0;
                        state_reg  <= S_DONE;
                    end
                    else if (best_n_reg[0] == '0 && best_n_reg[1] == '0 &&
                             best_n_reg[2] == '0)
                    begin
                        nrm_reg[0] <= '0;
                        nrm_reg[1] <= NW'(ONE_Q14);
                        nrm_reg[2] <= '0;
                        state_reg  <= S_DONE;
                    end
                    else
                    begin
                        state_reg <= S_NSHIFT;
                    end
                end

                // bring all three parts under 31 bits by a common shift
                S_NSHIFT:
                begin
                    if (|m_or[XW-1:NORM_BITS])
                    begin
                        m_reg[0] <= m_reg[0] >> 1;
                        m_reg[1] <= m_reg[1] >> 1;
                        m_reg[2] <= m_reg[2] >> 1;
                    end
                    else
                    begin
                        state_reg <= S_NSQ;
                    end
                end

                S_NSQ:
                begin
                    if (!phase_reg)
                    begin
                        prod_reg  <= op_a * op_b;
                        phase_reg <= 1'b1;
                    end
                    else
                    begin
                        acc_reg   <= acc_sum;
                        phase_reg <= 1'b0;
                        if (comp_reg == 2'd2)
                        begin
                            sq_v_reg  <= acc_sum[SQ_W-1:0];
                            sq_r_reg  <= '0;
                            sq_b_reg  <= SQ_W'(1) << (SQ_W - 2);
                            step_reg  <= '0;
                            comp_reg  <= '0;
                            state_reg <= S_SQRT;
                        end
                        else
                        begin
                            comp_reg <= comp_reg + 2'd1;
                        end
                    end
                end

                S_SQRT:
                begin
                    if (sq_ge)
                    begin
                        sq_v_reg <= sq_v_reg - sq_sum[SQ_W-1:0];
                        sq_r_reg <= (sq_r_reg >> 1) + sq_b_reg;
                    end
                    else
                    begin
                        sq_r_reg <= sq_r_reg >> 1;
                    end
                    sq_b_reg <= sq_b_reg >> 2;
                    step_reg <= step_reg + 6'd1;
                    if (step_reg == 6'(SQ_W / 2 - 1))
                    begin
                        state_reg <= S_NDSET;
                    end
                end

                S_NDSET:
                begin
                    if (step_reg != '0)
                    begin
                        // first pass after the root: latch the length
                        len_reg  <= (sq_r_reg == '0) ? LEN_W'(1) : sq_r_reg[LEN_W-1:0];
                        step_reg <= '0;
                    end
                    else
                    begin
                        rem_reg     <= (ACC_W'(m_reg[comp_reg][NORM_BITS-1:0]) << NFRAC) +
                                       ACC_W'(len_reg >> 1);
                        dvs_reg     <= ACC_W'(len_reg) << NFRAC;
                        quo_reg     <= '0;
                        step_reg    <= 6'(NFRAC);
                        divmode_reg <= 1'b1;
                        state_reg   <= S_DIV;
                    end
                end

                S_NSTORE:
                begin
                    nrm_reg[comp_reg] <= n_neg ? -$signed(q_clamp) : $signed(q_clamp);
                    step_reg          <= '0;
                    if (comp_reg == 2'd2)
                    begin
                        state_reg <= S_DONE;
                    end
                    else
                    begin
                        comp_reg  <= comp_reg + 2'd1;
                        state_reg <= S_NDSET;
                    end
                end

                S_DONE:
                begin
                    if (!out_valid_reg || out_ready)
                    begin
                        out_valid_reg <= 1'b1;
                        hit_reg       <= found_reg;
                        height_reg    <= best_h_reg;
                        nx_reg        <= nrm_reg[0];
                        ny_reg        <= nrm_reg[1];
                        nz_reg        <= nrm_reg[2];
                        state_reg     <= S_IDLE;
                    end
                end

                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

    `TGHQ_ASSERT_IMP(a_load_room, state_reg == S_LOAD, count_reg < CNT_W'(MAX_TRIANGLES))
    `TGHQ_ASSERT_NXT(a_query_busy, in_valid && in_ready && cmd == CMD_QUERY, !in_ready)
    `TGHQ_ASSERT_IMP(a_miss_zero, out_valid && !hit_found, ground_height == 0 && normal_x == 0 && normal_y == 0 && normal_z == 0)
    `TGHQ_ASSERT_IMP(a_ny_nonneg, out_valid && hit_found, !normal_y[NW-1])

endmodule
